// ===== src/grid_coverage_nearest_unknown_core_macros.svh =====
// Assertion macros for the checker file of the coverage grid core
`ifndef GRID_COVERAGE_NEAREST_UNKNOWN_CORE_MACROS_SVH
`define GRID_COVERAGE_NEAREST_UNKNOWN_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define GCNU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcnu assertion failed");

// Next-cycle implication, clocked on clk, off during reset
`define GCNU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcnu assertion failed");

`endif

// ===== src/gcnu_pkg.sv =====
// Shared types and constants of the coverage grid core
`default_nettype none

package gcnu_pkg;

  // Width of the cell coordinate fields on the ports
  localparam int CELL_W = 5;
  // Width of the time and dwell fields
  localparam int TIME_W = 32;
  // Reset value of the dwell limit
  localparam logic [TIME_W-1:0] DWELL_RESET = 32'd1000;

  // Squared-distance limits of the mark patterns
  localparam int LIM_START  = 1;
  localparam int LIM_FORBID = 2;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_FORBID = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_MOVE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_UNKNOWN   = 2'd0,
    ST_CURRENT   = 2'd1,
    ST_SEARCHED  = 2'd2,
    ST_FORBIDDEN = 2'd3
  } status_t;

  // Operation of one grid sweep; OP_CLEAR is the post-reset wipe
  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_FORBID = 3'd1,
    OP_UPDATE = 3'd2,
    OP_MOVE   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_DRAIN = 2'd2,
    S_FIN   = 2'd3
  } state_t;

  // Sequencer to cell evaluator
  typedef struct packed {
    op_t  op;    // sweep operation
    logic vld;   // a cell's old status and distance arrive this cycle
    logic init;  // new item accepted: restart the nearest search
  } eval_ctl_t;

endpackage

`default_nettype wire

// ===== src/gcnu_mem.sv =====
// Cell status memory: one write port, one registered read port
`default_nettype none

module gcnu_mem import gcnu_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output status_t            rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire status_t       wr_data
);

  status_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/gcnu_dist.sv =====
// Shared squared-distance unit, one cell per cycle, registered result
`default_nettype none

module gcnu_dist import gcnu_pkg::*; #(
  parameter int XW = 5,
  parameter int YW = 5,
  parameter int DW = 6
) (
  input  wire logic              clk,
  input  wire logic [CELL_W-1:0] cx,
  input  wire logic [CELL_W-1:0] cy,
  input  wire logic [XW-1:0]     x,
  input  wire logic [YW-1:0]     y,
  output logic [2*DW-1:0]        d2_r
);

  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic signed [2*DW-1:0] px;
  logic signed [2*DW-1:0] py;
  logic [2*DW-1:0]        d2_nxt;

  // Differences are taken one bit wider than any coordinate
  always_comb begin
    dx     = $signed({1'b0, (DW-1)'(cx)}) - $signed({1'b0, (DW-1)'(x)});
    dy     = $signed({1'b0, (DW-1)'(cy)}) - $signed({1'b0, (DW-1)'(y)});
    px     = dx * dx;
    py     = dy * dy;
    d2_nxt = $unsigned(px) + $unsigned(py);
  end

  always_ff @(posedge clk) begin
    d2_r <= d2_nxt;
  end

endmodule

`default_nettype wire

// ===== src/gcnu_eval.sv =====
// Cell evaluator: new status for the swept cell and nearest-unknown tracking
`default_nettype none

module gcnu_eval import gcnu_pkg::*; #(
  parameter int XW  = 5,
  parameter int YW  = 5,
  parameter int D2W = 12
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire eval_ctl_t      ectl,
  input  wire status_t        old_st,
  input  wire logic [D2W-1:0] d2,
  input  wire logic [XW-1:0]  x,
  input  wire logic [YW-1:0]  y,
  output logic                wr_en,
  output status_t             wr_data,
  output logic                found_r,
  output logic [XW-1:0]       best_x_r,
  output logic [YW-1:0]       best_y_r
);

  logic [D2W-1:0] best_d2_r;
  logic [D2W-1:0] best_d2_nxt;
  logic [XW-1:0]  best_x_nxt;
  logic [YW-1:0]  best_y_nxt;
  logic           found_nxt;
  logic           take;

  // New status of the cell under the sweep
  always_comb begin
    wr_en = ectl.vld && (ectl.op != OP_MOVE);
    case (ectl.op)
      OP_CLEAR:  wr_data = ST_UNKNOWN;
      OP_START:  wr_data = (d2 <= D2W'(LIM_START)) ? ST_CURRENT : ST_UNKNOWN;
      OP_FORBID: wr_data = (d2 <= D2W'(LIM_FORBID)) ? ST_FORBIDDEN : old_st;
      OP_UPDATE: begin
        if (d2 == '0) begin
          wr_data = ST_CURRENT;
        end else if (old_st == ST_CURRENT) begin
          wr_data = ST_SEARCHED;
        end else begin
          wr_data = old_st;
        end
      end
      default:   wr_data = old_st;
    endcase
  end

  // Strict compare keeps the first cell in scan order on a tie
  always_comb begin
    take = ectl.vld && (ectl.op == OP_MOVE) && (old_st == ST_UNKNOWN) &&
           (!found_r || (d2 < best_d2_r));
    found_nxt   = found_r;
    best_d2_nxt = best_d2_r;
    best_x_nxt  = best_x_r;
    best_y_nxt  = best_y_r;
    if (ectl.init) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt   = 1'b1;
      best_d2_nxt = d2;
      best_x_nxt  = x;
      best_y_nxt  = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_d2_r <= best_d2_nxt;
    best_x_r  <= best_x_nxt;
    best_y_r  <= best_y_nxt;
  end

endmodule

`default_nettype wire

// ===== src/gcnu_ctrl.sv =====
// Sequencer: command intake, grid sweep counters and result timing
`default_nettype none

module gcnu_ctrl import gcnu_pkg::*; #(
  parameter int GW = 32,
  parameter int GL = 32,
  parameter int XW = 5,
  parameter int YW = 5,
  parameter int AW = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_command,
  input  wire logic [CELL_W-1:0] in_cell_x,
  input  wire logic [CELL_W-1:0] in_cell_y,
  input  wire logic [TIME_W-1:0] in_elapsed_time,
  input  wire logic [TIME_W-1:0] dwell_limit,
  input  wire logic              out_free,
  output logic                   out_load,
  output logic                   dwell_done,
  output logic [CELL_W-1:0]      cx_r,
  output logic [CELL_W-1:0]      cy_r,
  output logic [AW-1:0]          iss_addr,
  output logic [XW-1:0]          iss_x,
  output logic [YW-1:0]          iss_y,
  output logic [AW-1:0]          stg_addr,
  output logic [XW-1:0]          stg_x,
  output logic [YW-1:0]          stg_y,
  output eval_ctl_t              ectl
);

  state_t        state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic          pass_r, pass_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic          vld1_r;
  logic [AW-1:0] addr1_r;
  logic [XW-1:0] x1_r;
  logic [YW-1:0] y1_r;
  logic          accept;
  logic          last;
  logic          pass_in;
  op_t           op_in;

  // Command decode
  always_comb begin
    pass_in = (in_elapsed_time >= dwell_limit);
    unique case (cmd_t'(in_command))
      CMD_START:  op_in = OP_START;
      CMD_FORBID: op_in = OP_FORBID;
      CMD_UPDATE: op_in = OP_UPDATE;
      CMD_MOVE:   op_in = OP_MOVE;
      default:    op_in = OP_MOVE;
    endcase
  end

  assign last = (x_r == XW'(GW - 1)) && (y_r == YW'(GL - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = ((op_in != OP_MOVE) || pass_in) ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN: begin
        if ((op_r == OP_CLEAR) || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = (state_r != S_IDLE);
    accept   = (state_r == S_IDLE) && in_valid;
    out_load = (state_r == S_FIN) && (op_r != OP_CLEAR) && out_free;
  end

  // Sweep counters: column outer, row inner
  always_comb begin
    op_nxt   = op_r;
    pass_nxt = pass_r;
    addr_nxt = addr_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (accept) begin
      op_nxt   = op_in;
      pass_nxt = pass_in;
      addr_nxt = '0;
      x_nxt    = '0;
      y_nxt    = '0;
    end else if (state_r == S_SCAN) begin
      addr_nxt = addr_r + AW'(1);
      if (y_r == YW'(GL - 1)) begin
        y_nxt = '0;
        x_nxt = x_r + XW'(1);
      end else begin
        y_nxt = y_r + YW'(1);
      end
    end
  end

  // Control registers; reset starts the wipe of the grid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SCAN;
      op_r    <= OP_CLEAR;
      pass_r  <= 1'b0;
      addr_r  <= '0;
      x_r     <= '0;
      y_r     <= '0;
      vld1_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      pass_r  <= pass_nxt;
      addr_r  <= addr_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      vld1_r  <= (state_r == S_SCAN);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r <= in_cell_x;
      cy_r <= in_cell_y;
    end
    addr1_r <= addr_r;
    x1_r    <= x_r;
    y1_r    <= y_r;
  end

  always_comb begin
    dwell_done = (op_r == OP_MOVE) && pass_r;
    iss_addr   = addr_r;
    iss_x      = x_r;
    iss_y      = y_r;
    stg_addr   = addr1_r;
    stg_x      = x1_r;
    stg_y      = y1_r;
    ectl.op    = op_r;
    ectl.vld   = vld1_r;
    ectl.init  = accept;
  end

endmodule

`default_nettype wire

// ===== src/grid_coverage_nearest_unknown_core.sv =====
// Result: start, forbid, update and a move that reaches the dwell limit give their result
//   after a sweep of all GRID_WIDTH*GRID_LENGTH cells; a refused move skips the sweep.
// Items: a new item is taken only once the last one is through, with in_stall high until then;
//   the sweep runs one cell per cycle through the status memory and the distance unit.
// Reset: synchronous, active low; a wipe of all GRID_WIDTH*GRID_LENGTH cells follows,
//   in_stall high throughout, configuration writes still taken.
`default_nettype none

module grid_coverage_nearest_unknown_core import gcnu_pkg::*; #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_LENGTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_command,
  input  wire logic [CELL_W-1:0] in_cell_x,
  input  wire logic [CELL_W-1:0] in_cell_y,
  input  wire logic [TIME_W-1:0] in_elapsed_time,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_dwell_done,
  output logic                   out_found,
  output logic [CELL_W-1:0]      out_target_x,
  output logic [CELL_W-1:0]      out_target_y,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [TIME_W-1:0] cfg_dwell_limit
);

  localparam int DEPTH = GRID_WIDTH * GRID_LENGTH;
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_LENGTH);
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = (XW > YW) ? XW : YW;
  localparam int DW    = ((MW > CELL_W) ? MW : CELL_W) + 1;
  localparam int D2W   = 2 * DW;
  localparam int XE    = (XW > CELL_W) ? XW : CELL_W;
  localparam int YE    = (YW > CELL_W) ? YW : CELL_W;

  logic [TIME_W-1:0] dwell_limit_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              out_load;
  logic              dwell_done;
  logic [CELL_W-1:0] cx_r, cy_r;
  logic [AW-1:0]     iss_addr, stg_addr;
  logic [XW-1:0]     iss_x, stg_x, best_x;
  logic [YW-1:0]     iss_y, stg_y, best_y;
  eval_ctl_t         ectl;
  status_t           rd_data, wr_data;
  logic              wr_en;
  logic [D2W-1:0]    d2;
  logic              found;
  logic [XE-1:0]     best_x_ext;
  logic [YE-1:0]     best_y_ext;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_limit_r <= DWELL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dwell_limit_r <= cfg_dwell_limit;
    end
  end

  gcnu_ctrl #(
    .GW (GRID_WIDTH),
    .GL (GRID_LENGTH),
    .XW (XW),
    .YW (YW),
    .AW (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_cell_x       (in_cell_x),
    .in_cell_y       (in_cell_y),
    .in_elapsed_time (in_elapsed_time),
    .dwell_limit     (dwell_limit_r),
    .out_free        (out_free),
    .out_load        (out_load),
    .dwell_done      (dwell_done),
    .cx_r            (cx_r),
    .cy_r            (cy_r),
    .iss_addr        (iss_addr),
    .iss_x           (iss_x),
    .iss_y           (iss_y),
    .stg_addr        (stg_addr),
    .stg_x           (stg_x),
    .stg_y           (stg_y),
    .ectl            (ectl)
  );

  gcnu_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (iss_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (stg_addr),
    .wr_data (wr_data)
  );

  gcnu_dist #(
    .XW (XW),
    .YW (YW),
    .DW (DW)
  ) u_dist (
    .clk  (clk),
    .cx   (cx_r),
    .cy   (cy_r),
    .x    (iss_x),
    .y    (iss_y),
    .d2_r (d2)
  );

  gcnu_eval #(
    .XW  (XW),
    .YW  (YW),
    .D2W (D2W)
  ) u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .ectl     (ectl),
    .old_st   (rd_data),
    .d2       (d2),
    .x        (stg_x),
    .y        (stg_y),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .found_r  (found),
    .best_x_r (best_x),
    .best_y_r (best_y)
  );

  // Output register; a held result does not block the sweep of the next item, only its result
  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);
  assign best_x_ext    = XE'(best_x);
  assign best_y_ext    = YE'(best_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dwell_done <= dwell_done;
      out_found      <= found;
      out_target_x   <= found ? best_x_ext[CELL_W-1:0] : cx_r;
      out_target_y   <= found ? best_y_ext[CELL_W-1:0] : cy_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/gcnu_checker.sv =====
// Port-level checker of the coverage grid core and its bind
`default_nettype none
`include "grid_coverage_nearest_unknown_core_macros.svh"

module gcnu_checker import gcnu_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_dwell_done,
  input wire logic              out_found,
  input wire logic [CELL_W-1:0] out_target_x,
  input wire logic [CELL_W-1:0] out_target_y
);

  // An accepted item keeps the block busy in the next cycle
  `GCNU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // A found target only comes from a move that passed the dwell limit
  `GCNU_ASSERT_IMPL(a_found_needs_dwell, out_valid && out_found, out_dwell_done)

  // A stalled result stays offered
  `GCNU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A stalled result keeps its target
  `GCNU_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                    $stable(out_target_x) && $stable(out_target_y))

endmodule

bind grid_coverage_nearest_unknown_core gcnu_checker u_gcnu_checker (.*);

`default_nettype wire
